/* rtl/integer_to_ascii_formatter_defines.svh */
// Assertion macros for the integer to ASCII formatter.
// Needs signals clk and rst in the scope where the macros are used.
`ifndef INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define I2A_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define I2A_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/i2a_pkg.sv */
// Shared types, constants and character helpers for the integer to ASCII formatter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package i2a_pkg;

  localparam int OPCODE_W   = 3;
  localparam int VALUE_W    = 64;
  localparam int LOW_W      = 32;
  localparam int CHAR_W     = 8;
  localparam int TOTAL_W    = 31;
  localparam int DIGIT_W    = 4;
  localparam int STACK_DEPTH = 16;
  localparam int STACK_IDX_W = $clog2(STACK_DEPTH);
  localparam int STACK_CNT_W = STACK_IDX_W + 1;
  localparam int PIDX_W     = 3;

  // Reciprocal of ten: (n * RECIP_10) >> RECIP_SHIFT == n / 10 for any 32-bit n
  localparam logic [LOW_W-1:0] RECIP_10    = 32'hCCCC_CCCD;
  localparam int               RECIP_SHIFT = 35;

  // Request opcodes
  localparam logic [OPCODE_W-1:0] OP_SDEC = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_UDEC = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_LHEX = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_UHEX = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_PTR  = 3'd4;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  typedef enum logic [1:0] {
    PFX_NONE,
    PFX_MINUS,
    PFX_HEX,
    PFX_NIL
  } prefix_t;

  // Sequencer to digit unit
  typedef struct packed {
    logic               load;
    logic               decimal;
    logic               step;
    logic               pop;
    logic [VALUE_W-1:0] operand;
  } du_ctrl_t;

  // Digit unit back to sequencer
  typedef struct packed {
    logic                   last_digit;
    logic [STACK_CNT_W-1:0] depth;
    logic [DIGIT_W-1:0]     top;
  } du_stat_t;

  function automatic logic [PIDX_W-1:0] prefix_len(prefix_t kind);
    logic [PIDX_W-1:0] len;
    unique case (kind)
      PFX_NONE:  len = 3'd0;
      PFX_MINUS: len = 3'd1;
      PFX_HEX:   len = 3'd2;
      PFX_NIL:   len = 3'd5;
      default:   len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic [CHAR_W-1:0] prefix_char(prefix_t kind, logic [PIDX_W-1:0] idx);
    logic [CHAR_W-1:0] c;
    c = "0";
    unique case (kind)
      PFX_MINUS: c = "-";
      PFX_HEX:   c = (idx == 3'd0) ? "0" : "x";
      PFX_NIL: begin
        unique case (idx)
          3'd0:    c = "(";
          3'd1:    c = "n";
          3'd2:    c = "i";
          3'd3:    c = "l";
          default: c = ")";
        endcase
      end
      default:   c = "0";
    endcase
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(logic [DIGIT_W-1:0] d, logic upper);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = 8'h30 + {4'h0, d};
    end else begin
      c = (upper ? 8'h41 : 8'h61) + {4'h0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/i2a_digit_unit.sv */
// Shared digit extractor: divide-by-ten or nibble shift per cycle, plus a digit stack.
// Depends on i2a_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2a_digit_unit (
  input  logic              clk,
  input  logic              rst,
  input  i2a_pkg::du_ctrl_t ctrl,
  output i2a_pkg::du_stat_t stat
);
  import i2a_pkg::*;

  logic [VALUE_W-1:0]     work;
  logic                   decimal;
  logic [DIGIT_W-1:0]     stack [STACK_DEPTH];
  logic [STACK_CNT_W-1:0] depth;

  logic [2*LOW_W-1:0]     prod;
  logic [LOW_W-1:0]       dec_q;
  logic [LOW_W-1:0]       dec_q10;
  logic [LOW_W-1:0]       dec_rem;
  logic [VALUE_W-1:0]     quot;
  logic [DIGIT_W-1:0]     digit;
  logic [STACK_CNT_W-1:0] depth_m1;

  // One division step: quotient and the digit that falls out
  always_comb begin
    prod    = work[LOW_W-1:0] * RECIP_10;
    dec_q   = LOW_W'(prod >> RECIP_SHIFT);
    dec_q10 = (dec_q << 3) + (dec_q << 1);
    dec_rem = work[LOW_W-1:0] - dec_q10;
    if (decimal) begin
      quot  = {{(VALUE_W-LOW_W){1'b0}}, dec_q};
      digit = dec_rem[DIGIT_W-1:0];
    end else begin
      quot  = work >> DIGIT_W;
      digit = work[DIGIT_W-1:0];
    end
  end

  // Working value
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      work    <= ctrl.operand;
      decimal <= ctrl.decimal;
    end else if (ctrl.step) begin
      work    <= quot;
    end
  end

  // Digit stack, least significant pushed first
  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      stack[depth[STACK_IDX_W-1:0]] <= digit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else if (ctrl.load) begin
      depth <= '0;
    end else if (ctrl.step) begin
      depth <= depth + 1'b1;
    end else if (ctrl.pop) begin
      depth <= depth_m1;
    end
  end

  assign depth_m1        = depth - 1'b1;
  assign stat.last_digit = (quot == '0);
  assign stat.depth      = depth;
  assign stat.top        = stack[depth_m1[STACK_IDX_W-1:0]];

endmodule

`default_nettype wire

/* rtl/integer_to_ascii_formatter.sv */
// Integer to ASCII formatter top level: request decode, sequencer, output register.
// Depends on i2a_pkg, i2a_digit_unit and integer_to_ascii_formatter_defines.svh.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid, in_ready, opcode, value         | request
//   out     | out_valid, out_ready, character,          | one char
//           | last_of_run, running_length               |   a beat
//
// A request is accepted while idle, then the shared divide-by-ten / nibble-shift
// unit extracts its digits (up to 10 decimal, 16 hex, none for "(nil)") and
// the characters are emitted, prefix first. Output stalls hold the sequencer;
// in_ready is high only while idle. Reset clears the sequencer and the
// character total.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_ascii_formatter (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [i2a_pkg::OPCODE_W-1:0]   opcode,
  input  logic [i2a_pkg::VALUE_W-1:0]    value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [i2a_pkg::CHAR_W-1:0]     character,
  output logic                           last_of_run,
  output logic [i2a_pkg::TOTAL_W-1:0]    running_length
);
  import i2a_pkg::*;

  `include "integer_to_ascii_formatter_defines.svh"

  state_t            state, state_next;
  prefix_t           pfx, pfx_next;
  logic [PIDX_W-1:0] pre_idx;
  logic              upper, upper_next;
  logic [TOTAL_W-1:0] total, total_next;

  du_ctrl_t          ctrl;
  du_stat_t          stat;

  logic              accept;
  logic              op_ok;
  logic              go_conv;
  logic              op_decimal;
  logic [VALUE_W-1:0] op_operand;
  logic [LOW_W-1:0]  low;
  logic [PIDX_W-1:0] plen;
  logic              in_pre;
  logic              emit_load;
  logic [CHAR_W-1:0] char_next;
  logic              last_next;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign low      = value[LOW_W-1:0];

  // Request decode
  always_comb begin
    op_ok      = 1'b1;
    go_conv    = 1'b1;
    pfx_next   = PFX_NONE;
    upper_next = 1'b0;
    op_decimal = 1'b0;
    op_operand = {{(VALUE_W-LOW_W){1'b0}}, low};
    unique case (opcode)
      OP_SDEC: begin
        op_decimal = 1'b1;
        if (low[LOW_W-1]) begin
          pfx_next   = PFX_MINUS;
          op_operand = {{(VALUE_W-LOW_W){1'b0}}, LOW_W'(-low)};
        end
      end
      OP_UDEC: op_decimal = 1'b1;
      OP_LHEX: ;
      OP_UHEX: upper_next = 1'b1;
      OP_PTR: begin
        op_operand = value;
        if (value == '0) begin
          pfx_next = PFX_NIL;
          go_conv  = 1'b0;
        end else begin
          pfx_next = PFX_HEX;
        end
      end
      default: op_ok = 1'b0;
    endcase
  end

  // Character selection: prefix first, then digits off the stack
  assign plen      = prefix_len(pfx);
  assign in_pre    = (pre_idx < plen);
  assign emit_load = (state == ST_EMIT) && (!out_valid || out_ready);

  // Digit unit control
  assign ctrl = '{load:    accept && op_ok,
                  decimal: op_decimal,
                  step:    (state == ST_CONV),
                  pop:     emit_load && !in_pre,
                  operand: op_operand};

  always_comb begin
    if (in_pre) begin
      char_next = prefix_char(pfx, pre_idx);
      last_next = (pre_idx == plen - 1'b1) && (stat.depth == '0);
    end else begin
      char_next = digit_char(stat.top, upper);
      last_next = (stat.depth == STACK_CNT_W'(1));
    end
  end

  assign total_next = (total == TOTAL_MAX) ? total : total + 1'b1;

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        priority if (ctrl.load && go_conv) begin
          state_next = ST_CONV;
        end else if (ctrl.load) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_CONV: if (stat.last_digit) state_next = ST_EMIT;
      ST_EMIT: if (emit_load && last_next) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit_load) begin
        total     <= total_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request context and prefix position
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      pfx     <= pfx_next;
      upper   <= upper_next;
      pre_idx <= '0;
    end else if (emit_load && in_pre) begin
      pre_idx <= pre_idx + 1'b1;
    end
  end

  // Output beat register
  always_ff @(posedge clk) begin
    if (emit_load) begin
      character      <= char_next;
      last_of_run    <= last_next;
      running_length <= total_next;
    end
  end

  i2a_digit_unit u_digits (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .stat (stat)
  );

  // A beat that is not the last of its run means the sequencer is still emitting
  `I2A_ASSERT_NOW(a_mid_run_emitting, out_valid && !last_of_run, state == ST_EMIT, "mid-run beat outside emit")
  // Digit extraction only ever hands over to emission
  `I2A_ASSERT_NEXT(a_conv_exit, state == ST_CONV, state == ST_CONV || state == ST_EMIT, "bad exit from conversion")
  // The digit stack never overflows
  `I2A_ASSERT_NOW(a_stack_bound, state == ST_CONV, stat.depth < STACK_CNT_W'(STACK_DEPTH), "digit stack overflow")

endmodule

`default_nettype wire

/* verif/integer_to_ascii_formatter_checker.sv */
// Scoreboard for the integer to ASCII formatter: predicts the text of each request beat.
// Depends on i2a_pkg for widths and opcode names; watches both channels of the block.
`timescale 1ns / 1ps

module integer_to_ascii_formatter_checker
  import i2a_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [OPCODE_W-1:0] opcode,
  input  logic [VALUE_W-1:0]  value,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [CHAR_W-1:0]   character,
  input  logic                last_of_run,
  input  logic [TOTAL_W-1:0]  running_length,
  output int                  fail_count,
  output int                  pending_chars
);

  typedef struct packed {
    logic [CHAR_W-1:0]  ch;
    logic               last;
    logic [TOTAL_W-1:0] total;
  } char_beat_t;

  char_beat_t         text_queue[$];
  logic [TOTAL_W-1:0] emitted_total;

  initial begin
    fail_count    = 0;
    pending_chars = 0;
    emitted_total = '0;
  end

  // Builds the printf text of one request and queues its characters
  function automatic void queue_request_text(logic [OPCODE_W-1:0] op, logic [VALUE_W-1:0] v);
    logic [CHAR_W-1:0] text[$];
    logic [CHAR_W-1:0] digits[$];
    logic [VALUE_W-1:0] num;
    logic [VALUE_W-1:0] radix;
    logic [VALUE_W-1:0] d;
    logic [LOW_W-1:0]   low;
    logic               upper;
    string              nil_word;
    char_beat_t         beat;
    low      = v[LOW_W-1:0];
    num      = {32'd0, low};
    radix    = 64'd16;
    upper    = 1'b0;
    nil_word = "(nil)";
    case (op)
      OP_SDEC: begin
        radix = 64'd10;
        if (low[LOW_W-1]) begin
          text.push_back("-");
          num = {32'd0, 32'd0 - low};
        end
      end
      OP_UDEC: radix = 64'd10;
      OP_LHEX: radix = 64'd16;
      OP_UHEX: upper = 1'b1;
      OP_PTR: begin
        if (v == '0) begin
          for (int i = 0; i < nil_word.len(); i++) text.push_back(nil_word[i]);
          radix = 64'd0;
        end else begin
          text.push_back("0");
          text.push_back("x");
          num = v;
        end
      end
      default: return; // unused opcodes are dropped silently
    endcase
    // digits come out least significant first
    if (radix != 64'd0) begin
      do begin
        d = num % radix;
        if (d < 10) digits.push_front(8'h30 + d[7:0]);
        else digits.push_front((upper ? 8'h41 : 8'h61) + d[7:0] - 8'd10);
        num = num / radix;
      end while (num != 0);
      foreach (digits[i]) text.push_back(digits[i]);
    end
    // running total saturates at its top value
    foreach (text[k]) begin
      if (emitted_total != TOTAL_MAX) emitted_total = emitted_total + 1'b1;
      beat.ch    = text[k];
      beat.last  = (k == text.size() - 1);
      beat.total = emitted_total;
      text_queue.push_back(beat);
    end
  endfunction

  // Output beats are checked before the new request is queued
  always @(posedge clk) begin
    char_beat_t want;
    if (rst) begin
      text_queue.delete();
      emitted_total = '0;
    end else begin
      if (out_valid && out_ready) begin
        if (text_queue.size() == 0) begin
          $display("%0t: unexpected beat char %h last %b length %0d", $time,
                   character, last_of_run, running_length);
          fail_count++;
        end else begin
          want = text_queue.pop_front();
          if (character !== want.ch) begin
            $display("%0t: character expected %h got %h", $time, want.ch, character);
            fail_count++;
          end
          if (last_of_run !== want.last) begin
            $display("%0t: last_of_run expected %b got %b", $time, want.last, last_of_run);
            fail_count++;
          end
          if (running_length !== want.total) begin
            $display("%0t: running_length expected %0d got %0d", $time, want.total,
                     running_length);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) queue_request_text(opcode, value);
    end
    pending_chars = text_queue.size();
  end

endmodule

/* verif/integer_to_ascii_formatter_tb.sv */
// Testbench top for the integer to ASCII formatter: clock, reset, requests, receiver.
// Depends on i2a_pkg, integer_to_ascii_formatter and integer_to_ascii_formatter_checker.
`timescale 1ns / 1ps

module integer_to_ascii_formatter_tb;
  import i2a_pkg::*;

  localparam int RANDOM_REQUESTS = 230;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int LONG_HOLD       = 300;

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [OPCODE_W-1:0] opcode;
  logic [VALUE_W-1:0]  value;
  logic                out_valid;
  logic                out_ready;
  logic [CHAR_W-1:0]   character;
  logic                last_of_run;
  logic [TOTAL_W-1:0]  running_length;
  int                  fail_count;
  int                  pending_chars;
  int                  cycle_count = 0;
  int                  request_idx = 0;
  int                  beat_idx = 0;

  always #2 clk = ~clk;

  integer_to_ascii_formatter u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .value          (value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .character      (character),
    .last_of_run    (last_of_run),
    .running_length (running_length)
  );

  integer_to_ascii_formatter_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .value          (value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .character      (character),
    .last_of_run    (last_of_run),
    .running_length (running_length),
    .fail_count     (fail_count),
    .pending_chars  (pending_chars)
  );

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // One request beat; a gap drops valid, no gap keeps it high into the next item
  task automatic send_request(logic [OPCODE_W-1:0] op, logic [VALUE_W-1:0] v);
    int gap;
    gap = (request_idx >= 100 && request_idx < 150) ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    value    <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    request_idx++;
  endtask

  // Values of every digit length, plus the sign and width corners
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] full;
    full = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0:       return full;
      1:       return full >> $urandom_range(0, 63);
      2:       return {full[63:32], 32'h8000_0000 ^ (full[31:0] >> $urandom_range(4, 31))};
      3:       return 64'($urandom_range(0, 20));
      4:       return {full[63:32], 32'hFFFF_FFFF - 32'($urandom_range(0, 20))};
      default: return full >> $urandom_range(32, 63);
    endcase
  endfunction

  // Receiver: random stalls, a stall-free window, and one long hold-off
  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (beat_idx == 250) gap = LONG_HOLD;
      else if (beat_idx >= 600 && beat_idx < 900) gap = 0;
      else gap = $urandom_range(0, 5);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      beat_idx++;
    end
  end

  // Requests and verdict
  initial begin
    logic [OPCODE_W-1:0] op;
    rst      = 1'b1;
    in_valid = 1'b0;
    opcode   = OP_SDEC;
    value    = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners
    send_request(OP_SDEC, 64'h0);
    send_request(OP_SDEC, 64'h0000_0000_8000_0000); // most negative int
    send_request(OP_SDEC, 64'h0000_0000_7FFF_FFFF);
    send_request(OP_SDEC, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(OP_SDEC, 64'hDEAD_BEEF_0000_007B); // upper half ignored
    send_request(OP_UDEC, 64'h0);
    send_request(OP_UDEC, 64'h0000_0000_FFFF_FFFF);
    send_request(OP_UDEC, 64'd1000000000);
    send_request(OP_UDEC, 64'd9);
    send_request(OP_UDEC, 64'd10);
    send_request(OP_LHEX, 64'h0);
    send_request(OP_LHEX, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(OP_LHEX, 64'h0000_0000_0123_ABCD);
    send_request(OP_UHEX, 64'h0);
    send_request(OP_UHEX, 64'h0000_0000_FFFF_FFFF);
    send_request(OP_UHEX, 64'h1234_5678_ABCD_EF09);
    send_request(OP_PTR,  64'h0);                   // nil pointer
    send_request(OP_PTR,  64'hFFFF_FFFF_FFFF_FFFF);
    send_request(OP_PTR,  64'h1);
    send_request(OP_PTR,  64'hFFFF_FFFF_0000_0000);
    send_request(OP_PTR,  64'h8000_0000_0000_0000);
    send_request(3'd5,    64'hFFFF_FFFF_FFFF_FFFF); // unused opcodes
    send_request(3'd6,    64'h0);
    send_request(3'd7,    64'h0000_0000_8000_0000);

    // random requests, a few of them with unused opcodes
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      op = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                       : 3'($urandom_range(OP_SDEC, OP_PTR));
      send_request(op, ($urandom_range(0, 15) == 0) ? 64'h0 : pick_value());
    end
    in_valid <= 1'b0;

    // drain, then allow for a request still in flight
    @(posedge clk);
    while (pending_chars != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
